// ===== design/itsi_pkg.sv =====
package itsi_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int NVAL        = 10;
	localparam int STAMP_W     = 48;
	localparam int GAP_W       = 24;

	// weight of one in Q1.30
	localparam logic [30:0] WONE = 31'h4000_0000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_GAP   = 2'd2;

	localparam logic [2:0] REG_MAX_GAP = 3'd0;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic [STAMP_W-1:0]        stamp;
		logic [NVAL-1:0][31:0]     vals;
	} row_t;

endpackage

// ===== design/itsi_store.sv =====
module itsi_store (
	input  logic            clk,
	input  logic            wr_en,
	input  itsi_pkg::addr_t wr_addr,
	input  itsi_pkg::row_t  wr_row,
	input  logic            rd_en,
	input  itsi_pkg::addr_t rd_addr_a,
	input  itsi_pkg::addr_t rd_addr_b,
	output itsi_pkg::row_t  rd_row_a,
	output itsi_pkg::row_t  rd_row_b
);
	import itsi_pkg::*;

	row_t mem_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_a <= mem_q[rd_addr_a];
			rd_row_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== design/itsi_mul.sv =====
module itsi_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);
	import itsi_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== design/itsi_sub.sv =====
module itsi_sub (
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        ge,
	output logic [63:0] diff
);
	import itsi_pkg::*;

	logic [64:0] d;

	assign d    = {1'b0, a} - {1'b0, b};
	assign ge   = ~d[64];
	assign diff = d[63:0];

endmodule

// ===== design/imu_time_sync_interpolator.sv =====
// IMU sample queue with time-synced interpolation. A word with req_type 0 stores
// a sample in a 16-entry ring (the oldest is overwritten when full). A word with
// req_type 1 asks for a sample at the given time and yields one result word:
// stale samples are popped one at a time, then a 30-step restoring division
// forms the weight, the ten fields are blended through one shared 33x33
// multiplier, the quaternion norm goes through a 32-step square root and up to
// four 31-step divisions on one shared subtractor. The input is not ready
// during that work.
// max_gap sits at byte address 0 of the APB port.
module imu_time_sync_interpolator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [47:0]         stamp,
	input  logic signed [31:0]  acc_x,
	input  logic signed [31:0]  acc_y,
	input  logic signed [31:0]  acc_z,
	input  logic signed [31:0]  gyro_x,
	input  logic signed [31:0]  gyro_y,
	input  logic signed [31:0]  gyro_z,
	input  logic signed [31:0]  quat_x,
	input  logic signed [31:0]  quat_y,
	input  logic signed [31:0]  quat_z,
	input  logic signed [31:0]  quat_w,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [47:0]         out_stamp,
	output logic signed [31:0]  out_acc_x,
	output logic signed [31:0]  out_acc_y,
	output logic signed [31:0]  out_acc_z,
	output logic signed [31:0]  out_gyro_x,
	output logic signed [31:0]  out_gyro_y,
	output logic signed [31:0]  out_gyro_z,
	output logic signed [31:0]  out_quat_x,
	output logic signed [31:0]  out_quat_y,
	output logic signed [31:0]  out_quat_z,
	output logic signed [31:0]  out_quat_w
);
	import itsi_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_LOOP = 19'h00002,
		S_RD   = 19'h00004,
		S_CMPA = 19'h00008,
		S_CMPB = 19'h00010,
		S_SEL  = 19'h00020,
		S_DEN  = 19'h00040,
		S_NEG  = 19'h00080,
		S_WCMP = 19'h00100,
		S_WDIV = 19'h00200,
		S_MA   = 19'h00400,
		S_MB   = 19'h00800,
		S_MC   = 19'h01000,
		S_SQ   = 19'h02000,
		S_SQA  = 19'h04000,
		S_SQRT = 19'h08000,
		S_NSET = 19'h10000,
		S_NDIV = 19'h20000,
		S_OUT  = 19'h40000
	} state_t;

	state_t              state_q;
	addr_t               head_q;
	logic [CNT_W-1:0]    count_q;
	logic [GAP_W-1:0]    gap_q;
	logic [STAMP_W-1:0]  t_q;
	logic [1:0]          status_q;
	logic signed [49:0]  num_q;
	logic signed [49:0]  den_q;
	logic [30:0]         wb_q;
	logic [63:0]         r_q;
	logic [31:0]         quo_q;
	logic [4:0]          cnt_q;
	logic [3:0]          fi_q;
	logic signed [65:0]  acc_q;
	logic signed [33:0]  v_q [NVAL];
	logic [63:0]         ssum_q;
	logic [63:0]         res_q;
	logic [63:0]         bit_q;
	logic [31:0]         h_q;
	logic [30:0]         n_q;
	logic [31:0]         o_q [NVAL];
	logic                out_valid_q;
	logic [1:0]          status_o_q;
	logic [47:0]         stamp_o_q;
	logic [31:0]         val_o_q [NVAL];

	// store
	logic  wr_en, rd_en;
	addr_t wr_addr, rd_addr_a, rd_addr_b;
	row_t  wr_row, rf, rb;

	assign wr_en   = (state_q == S_IDLE) && in_valid && !req_type;
	assign wr_addr = head_q + count_q[ADDR_W-1:0];
	assign wr_row  = '{stamp: stamp,
		vals: {quat_w, quat_z, quat_y, quat_x, gyro_z, gyro_y, gyro_x, acc_z, acc_y, acc_x}};
	assign rd_en     = (state_q == S_RD) || (state_q == S_SEL);
	assign rd_addr_a = head_q;
	assign rd_addr_b = (state_q == S_SEL && count_q == CNT_W'(1)) ? head_q : head_q + 1'b1;

	itsi_store u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_row(wr_row),
		.rd_en(rd_en), .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
		.rd_row_a(rf), .rd_row_b(rb)
	);

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [30:0]        wf;

	assign wf = WONE - wb_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MA: begin
				mul_a = {rf.vals[fi_q][31], rf.vals[fi_q]};
				mul_b = {2'b00, wf};
			end
			S_MB: begin
				mul_a = {rb.vals[fi_q][31], rb.vals[fi_q]};
				mul_b = {2'b00, wb_q};
			end
			S_SQ: begin
				mul_a = v_q[fi_q][32:0];
				mul_b = v_q[fi_q][32:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	itsi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	// shared subtractor
	logic [63:0] sub_a, sub_b, sub_d;
	logic        sub_ge;
	logic [63:0] r2;
	logic [33:0] qm;
	logic [60:0] nn;

	assign qm = v_q[fi_q][33] ? -v_q[fi_q] : v_q[fi_q];
	assign nn = {qm[31:0], 29'b0} + {30'b0, h_q[31:1]};

	always_comb begin
		r2    = '0;
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			S_WDIV: begin
				r2    = {r_q[62:0], 1'b0};
				sub_a = r2;
				sub_b = {14'b0, den_q};
			end
			S_SQRT: begin
				sub_a = r_q;
				sub_b = res_q + bit_q;
			end
			S_NSET: begin
				sub_a = {3'b0, nn};
				sub_b = {1'b0, h_q, 31'b0};
			end
			S_NDIV: begin
				r2    = {r_q[62:0], n_q[30]};
				sub_a = r2;
				sub_b = {32'b0, h_q};
			end
			default: begin
				r2    = '0;
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	itsi_sub u_sub (.a(sub_a), .b(sub_b), .ge(sub_ge), .diff(sub_d));

	// misc datapath
	logic [47:0] dtf, dbt;
	logic [65:0] blend;
	logic [63:0] ssum_n;
	logic [63:0] res_n;
	logic [30:0] ndq;

	assign dtf    = t_q - rf.stamp;
	assign dbt    = rb.stamp - t_q;
	assign blend  = (acc_q + mul_p + 66'sd536870912) >>> 30;
	assign ssum_n = ssum_q + {2'b0, mul_p[63:2]};
	assign res_n  = sub_ge ? (res_q >> 1) + bit_q : res_q >> 1;
	assign ndq    = {quo_q[29:0], sub_ge};

	function automatic logic [31:0] signed_mag(input logic neg, input logic [31:0] m);
		return neg ? -m : m;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_MAX_GAP) ? {8'b0, gap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			gap_q       <= GAP_W'(200000);
			out_valid_q <= 1'b0;
			t_q         <= '0;
			status_q    <= ST_OK;
			num_q       <= '0;
			den_q       <= '0;
			wb_q        <= '0;
			r_q         <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			fi_q        <= '0;
			acc_q       <= '0;
			ssum_q      <= '0;
			res_q       <= '0;
			bit_q       <= '0;
			h_q         <= '0;
			n_q         <= '0;
			status_o_q  <= ST_OK;
			stamp_o_q   <= '0;
			for (int i = 0; i < NVAL; i++) begin
				v_q[i]     <= '0;
				o_q[i]     <= '0;
				val_o_q[i] <= '0;
			end
		end else begin
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				gap_q <= pwdata[GAP_W-1:0];
			end
			// S_OUT reloads the output word itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!req_type) begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) head_q <= head_q + 1'b1;
							else count_q <= count_q + 1'b1;
						end else begin
							t_q      <= stamp;
							status_q <= ST_OK;
							state_q  <= S_LOOP;
						end
					end
				end
				S_LOOP: state_q <= (count_q >= CNT_W'(2)) ? S_RD : S_SEL;
				S_RD:   state_q <= S_CMPA;
				S_CMPA: begin
					if (rf.stamp > t_q) begin
						state_q <= S_SEL;
					end else if (rb.stamp < t_q) begin
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
						state_q <= S_LOOP;
					end else begin
						state_q <= S_CMPB;
					end
				end
				S_CMPB: begin
					if (dtf > {24'b0, gap_q}) begin
						head_q   <= head_q + 1'b1;
						count_q  <= count_q - 1'b1;
						status_q <= ST_GAP;
						state_q  <= S_OUT;
					end else if (dbt > {24'b0, gap_q}) begin
						status_q <= ST_GAP;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					if (count_q == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					num_q   <= $signed({2'b0, t_q}) - $signed({2'b0, rf.stamp});
					den_q   <= $signed({2'b0, rb.stamp}) - $signed({2'b0, rf.stamp});
					state_q <= S_NEG;
				end
				S_NEG: begin
					if (den_q == '0) begin
						for (int i = 0; i < NVAL; i++) o_q[i] <= rf.vals[i];
						state_q <= S_OUT;
					end else begin
						if (den_q < 0) begin
							num_q <= -num_q;
							den_q <= -den_q;
						end
						state_q <= S_WCMP;
					end
				end
				S_WCMP: begin
					fi_q <= '0;
					if (num_q <= 0) begin
						wb_q    <= '0;
						state_q <= S_MA;
					end else if (num_q >= den_q) begin
						wb_q    <= WONE;
						state_q <= S_MA;
					end else begin
						r_q     <= {14'b0, num_q};
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_WDIV;
					end
				end
				S_WDIV: begin
					r_q   <= sub_ge ? sub_d : r2;
					quo_q <= {quo_q[30:0], sub_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd29) begin
						wb_q    <= {1'b0, quo_q[28:0], sub_ge};
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: begin
					acc_q   <= mul_p;
					state_q <= S_MC;
				end
				S_MC: begin
					v_q[fi_q] <= blend[33:0];
					o_q[fi_q] <= blend[31:0];
					if (fi_q == 4'd9) begin
						fi_q    <= 4'd6;
						ssum_q  <= '0;
						state_q <= S_SQ;
					end else begin
						fi_q    <= fi_q + 1'b1;
						state_q <= S_MA;
					end
				end
				S_SQ: state_q <= S_SQA;
				S_SQA: begin
					ssum_q <= ssum_n;
					if (fi_q == 4'd9) begin
						r_q     <= ssum_n;
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= S_SQRT;
					end else begin
						fi_q    <= fi_q + 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SQRT: begin
					if (sub_ge) r_q <= sub_d;
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						h_q     <= res_n[31:0];
						fi_q    <= 4'd6;
						state_q <= S_NSET;
					end
				end
				S_NSET: begin
					if (h_q == '0 || sub_ge) begin
						// zero norm passes through, quotient past 31 bits saturates
						o_q[fi_q] <= (h_q == '0) ? v_q[fi_q][31:0]
							: signed_mag(v_q[fi_q][33], 32'h7FFF_FFFF);
						if (fi_q == 4'd9) state_q <= S_OUT;
						else fi_q <= fi_q + 1'b1;
					end else begin
						r_q     <= {34'b0, nn[60:31]};
						n_q     <= nn[30:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					r_q   <= sub_ge ? sub_d : r2;
					n_q   <= {n_q[29:0], 1'b0};
					quo_q <= {quo_q[30:0], sub_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd30) begin
						o_q[fi_q] <= signed_mag(v_q[fi_q][33], {1'b0, ndq});
						if (fi_q == 4'd9) begin
							state_q <= S_OUT;
						end else begin
							fi_q    <= fi_q + 1'b1;
							state_q <= S_NSET;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_o_q  <= status_q;
						stamp_o_q   <= (status_q == ST_OK) ? t_q : '0;
						for (int i = 0; i < NVAL; i++)
							val_o_q[i] <= (status_q == ST_OK) ? o_q[i] : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_o_q;
	assign out_stamp  = stamp_o_q;
	assign out_acc_x  = val_o_q[0];
	assign out_acc_y  = val_o_q[1];
	assign out_acc_z  = val_o_q[2];
	assign out_gyro_x = val_o_q[3];
	assign out_gyro_y = val_o_q[4];
	assign out_gyro_z = val_o_q[5];
	assign out_quat_x = val_o_q[6];
	assign out_quat_y = val_o_q[7];
	assign out_quat_z = val_o_q[8];
	assign out_quat_w = val_o_q[9];

endmodule
